/* src/pbbc_pkg.sv */
// types, constants and axis arithmetic for the particle box collision core
// no dependencies; used by particle_bounce_box_collide_core and its checker
package pbbc_pkg;

    // value and factor formats
    localparam int VALUE_WIDTH = 24;
    localparam int FACTOR_W    = 16;
    localparam int LIMIT_W     = VALUE_WIDTH - 1;
    localparam int WIDE_W      = VALUE_WIDTH + FACTOR_W + 1;

    // configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;

    typedef logic [IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_LIMIT_X      = 3'd0;
    localparam reg_idx_t REG_LIMIT_Y      = 3'd1;
    localparam reg_idx_t REG_BOUNCE       = 3'd2;
    localparam reg_idx_t REG_SETTLE       = 3'd3;
    localparam reg_idx_t REG_MIN_SPEED    = 3'd4;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic        [LIMIT_W-1:0]     limit_t;
    typedef logic        [FACTOR_W-1:0]    factor_t;
    typedef logic signed [WIDE_W-1:0]      wide_t;

    localparam limit_t  LIMIT_RESET  = {LIMIT_W{1'b1}};
    localparam factor_t FACTOR_RESET = factor_t'(49152);

    localparam value_t VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam value_t VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam wide_t  WIDE_MAX  = {{(WIDE_W-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
    localparam wide_t  WIDE_MIN  = {{(WIDE_W-VALUE_WIDTH+1){1'b1}}, {(VALUE_WIDTH-1){1'b0}}};
    localparam wide_t  ROUND_WIDE = wide_t'(1 << (FACTOR_W-1));

    typedef struct packed {
        value_t pos_x;
        value_t pos_y;
        value_t vel_x;
        value_t vel_y;
        value_t ang_vel;
    } particle_t;

    // wall decision of one axis plus the registered factor products
    typedef struct packed {
        logic   hit;
        logic   bounce;
        value_t new_pos;
        wide_t  prod_v;
        wide_t  prod_o;
        wide_t  prod_a;
    } axis_t;

    typedef struct packed {
        particle_t part;
        axis_t     ax;
    } mid_t;

    typedef struct packed {
        value_t v;
        value_t o;
        value_t a;
    } trio_t;

    // saturate to the signed value range
    function automatic value_t sat_value(wide_t x);
        if (x > WIDE_MAX)
            return VALUE_MAX;
        else if (x < WIDE_MIN)
            return VALUE_MIN;
        else
            return value_t'(x[VALUE_WIDTH-1:0]);
    endfunction

    // wall test, new position and the three products for one axis
    function automatic axis_t axis_decide(value_t p, value_t v, value_t o, value_t a,
                                          limit_t lim, factor_t bf, factor_t sf,
                                          value_t min_speed);
        axis_t r;
        wide_t pw;
        wide_t vw;
        wide_t lw;
        wide_t mw;
        wide_t vabs;
        logic  right;
        pw    = wide_t'(p);
        vw    = wide_t'(v);
        lw    = wide_t'(lim);
        mw    = wide_t'(min_speed);
        vabs  = v[VALUE_WIDTH-1] ? -vw : vw;
        right = pw > lw;
        r.hit    = right | p[VALUE_WIDTH-1];
        r.bounce = right ? (vw > mw) : (vabs > mw);
        if (!r.hit)
            r.new_pos = p;
        else if (right)
            r.new_pos = r.bounce ? sat_value((lw <<< 1) - pw) : value_t'(lim);
        else
            r.new_pos = r.bounce ? sat_value(-pw) : '0;
        r.prod_v = vw * wide_t'(bf);
        r.prod_o = wide_t'(o) * wide_t'(sf);
        r.prod_a = wide_t'(a) * wide_t'(sf);
        return r;
    endfunction

    // rounding, sign flip and saturation of the velocity side
    function automatic trio_t axis_finish(axis_t r, value_t v, value_t o, value_t a);
        trio_t t;
        wide_t sv;
        wide_t so;
        wide_t sa;
        sv = (r.prod_v + ROUND_WIDE) >>> FACTOR_W;
        so = (r.prod_o + ROUND_WIDE) >>> FACTOR_W;
        sa = (r.prod_a + ROUND_WIDE) >>> FACTOR_W;
        t.v = v;
        t.o = o;
        t.a = a;
        if (r.hit && r.bounce)
        begin
            t.v = sat_value(-sv);
        end
        else if (r.hit)
        begin
            t.v = '0;
            t.o = sat_value(so);
            t.a = sat_value(sa);
        end
        return t;
    endfunction

endpackage

/* src/particle_bounce_box_collide_core.sv */
// particle box collision core: x wall, then y wall, five register stages
// depends on pbbc_pkg for types, register codes and the axis arithmetic
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------------------
//  input   | in_valid  | in_stall  | pos_x pos_y vel_x vel_y ang_vel
//  output  | out_valid | out_stall | new_pos_x new_pos_y new_vel_x new_vel_y
//          |           |           | new_ang_vel
//  config  | psel/penable/pwrite, paddr, pwdata, prdata, pready (always high)
//
// one transaction per cycle in steady state while out_stall is low
// stages: input reg, x wall test and multiply, x round, y wall test and multiply,
// y round into the output register
// each stage moves when the one after it is empty or moving, so bubbles fill
// reset clears the stage valid bits and restores the register defaults
module particle_bounce_box_collide_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  pbbc_pkg::value_t              pos_x,
    input  pbbc_pkg::value_t              pos_y,
    input  pbbc_pkg::value_t              vel_x,
    input  pbbc_pkg::value_t              vel_y,
    input  pbbc_pkg::value_t              ang_vel,
    output logic                          out_valid,
    input  logic                          out_stall,
    output pbbc_pkg::value_t              new_pos_x,
    output pbbc_pkg::value_t              new_pos_y,
    output pbbc_pkg::value_t              new_vel_x,
    output pbbc_pkg::value_t              new_vel_y,
    output pbbc_pkg::value_t              new_ang_vel,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pbbc_pkg::ADDR_W-1:0]   paddr,
    input  logic [pbbc_pkg::DATA_W-1:0]   pwdata,
    output logic [pbbc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    // configuration registers
    pbbc_pkg::limit_t  limit_x_reg;
    pbbc_pkg::limit_t  limit_y_reg;
    pbbc_pkg::factor_t bounce_reg;
    pbbc_pkg::factor_t settle_reg;
    pbbc_pkg::value_t  min_speed_reg;

    pbbc_pkg::reg_idx_t cfg_idx;
    logic               cfg_write;

    // pipeline stages
    pbbc_pkg::particle_t s1_reg;
    pbbc_pkg::mid_t      s2_reg;
    pbbc_pkg::mid_t      s2_next;
    pbbc_pkg::particle_t s3_reg;
    pbbc_pkg::particle_t s3_next;
    pbbc_pkg::mid_t      s4_reg;
    pbbc_pkg::mid_t      s4_next;
    pbbc_pkg::particle_t out_reg;
    pbbc_pkg::particle_t out_next;
    pbbc_pkg::trio_t     x_trio;
    pbbc_pkg::trio_t     y_trio;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s4_valid_reg;
    logic out_valid_reg;

    logic s1_ready;
    logic s2_ready;
    logic s3_ready;
    logic s4_ready;
    logic out_ready;

    // apb write and read
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[pbbc_pkg::ADDR_W-1:2];
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_x_reg   <= pbbc_pkg::LIMIT_RESET;
            limit_y_reg   <= pbbc_pkg::LIMIT_RESET;
            bounce_reg    <= pbbc_pkg::FACTOR_RESET;
            settle_reg    <= pbbc_pkg::FACTOR_RESET;
            min_speed_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                pbbc_pkg::REG_LIMIT_X:   limit_x_reg   <= pwdata[pbbc_pkg::LIMIT_W-1:0];
                pbbc_pkg::REG_LIMIT_Y:   limit_y_reg   <= pwdata[pbbc_pkg::LIMIT_W-1:0];
                pbbc_pkg::REG_BOUNCE:    bounce_reg    <= pwdata[pbbc_pkg::FACTOR_W-1:0];
                pbbc_pkg::REG_SETTLE:    settle_reg    <= pwdata[pbbc_pkg::FACTOR_W-1:0];
                pbbc_pkg::REG_MIN_SPEED:
                    min_speed_reg <= pwdata[pbbc_pkg::VALUE_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            pbbc_pkg::REG_LIMIT_X:   prdata = pbbc_pkg::DATA_W'(limit_x_reg);
            pbbc_pkg::REG_LIMIT_Y:   prdata = pbbc_pkg::DATA_W'(limit_y_reg);
            pbbc_pkg::REG_BOUNCE:    prdata = pbbc_pkg::DATA_W'(bounce_reg);
            pbbc_pkg::REG_SETTLE:    prdata = pbbc_pkg::DATA_W'(settle_reg);
            pbbc_pkg::REG_MIN_SPEED: prdata = pbbc_pkg::DATA_W'(min_speed_reg);
            default:                 prdata = '0;
        endcase
    end

    // ready chain from the output back to the input
    assign out_ready = !out_valid_reg || !out_stall;
    assign s4_ready  = !s4_valid_reg || out_ready;
    assign s3_ready  = !s3_valid_reg || s4_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_stall  = !s1_ready;

    // x wall test and products
    always_comb
    begin
        s2_next.part = s1_reg;
        s2_next.ax   = pbbc_pkg::axis_decide(s1_reg.pos_x, s1_reg.vel_x, s1_reg.vel_y,
                                             s1_reg.ang_vel, limit_x_reg, bounce_reg,
                                             settle_reg, min_speed_reg);
    end

    // x rounding and selection
    always_comb
    begin
        x_trio = pbbc_pkg::axis_finish(s2_reg.ax, s2_reg.part.vel_x, s2_reg.part.vel_y,
                                       s2_reg.part.ang_vel);
        s3_next         = s2_reg.part;
        s3_next.pos_x   = s2_reg.ax.new_pos;
        s3_next.vel_x   = x_trio.v;
        s3_next.vel_y   = x_trio.o;
        s3_next.ang_vel = x_trio.a;
    end

    // y wall test and products, on the x results
    always_comb
    begin
        s4_next.part = s3_reg;
        s4_next.ax   = pbbc_pkg::axis_decide(s3_reg.pos_y, s3_reg.vel_y, s3_reg.vel_x,
                                             s3_reg.ang_vel, limit_y_reg, bounce_reg,
                                             settle_reg, min_speed_reg);
    end

    // y rounding and selection
    always_comb
    begin
        y_trio = pbbc_pkg::axis_finish(s4_reg.ax, s4_reg.part.vel_y, s4_reg.part.vel_x,
                                       s4_reg.part.ang_vel);
        out_next         = s4_reg.part;
        out_next.pos_y   = s4_reg.ax.new_pos;
        out_next.vel_y   = y_trio.v;
        out_next.vel_x   = y_trio.o;
        out_next.ang_vel = y_trio.a;
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
            if (s4_ready)
                s4_valid_reg <= s3_valid_reg;
            if (out_ready)
                out_valid_reg <= s4_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_reg.pos_x   <= pos_x;
            s1_reg.pos_y   <= pos_y;
            s1_reg.vel_x   <= vel_x;
            s1_reg.vel_y   <= vel_y;
            s1_reg.ang_vel <= ang_vel;
        end
        if (s2_ready && s1_valid_reg)
            s2_reg <= s2_next;
        if (s3_ready && s2_valid_reg)
            s3_reg <= s3_next;
        if (s4_ready && s3_valid_reg)
            s4_reg <= s4_next;
        if (out_ready && s4_valid_reg)
            out_reg <= out_next;
    end

    // output channel
    assign out_valid   = out_valid_reg;
    assign new_pos_x   = out_reg.pos_x;
    assign new_pos_y   = out_reg.pos_y;
    assign new_vel_x   = out_reg.vel_x;
    assign new_vel_y   = out_reg.vel_y;
    assign new_ang_vel = out_reg.ang_vel;

endmodule

/* src/pbbc_checker.sv */
// port-level checks for particle_bounce_box_collide_core, bound to the top level
// depends on pbbc_pkg for widths and register codes
module pbbc_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input pbbc_pkg::value_t              new_pos_x,
    input pbbc_pkg::value_t              new_pos_y,
    input pbbc_pkg::value_t              new_vel_x,
    input pbbc_pkg::value_t              new_vel_y,
    input pbbc_pkg::value_t              new_ang_vel,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [pbbc_pkg::ADDR_W-1:0]   paddr,
    input logic [pbbc_pkg::DATA_W-1:0]   pwdata,
    input logic [pbbc_pkg::DATA_W-1:0]   prdata,
    input logic                          pready
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
    else $error("output transaction dropped while stalled");

    // a stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(new_pos_x) && $stable(new_pos_y) &&
            $stable(new_vel_x) && $stable(new_vel_y) && $stable(new_ang_vel))
    else $error("output payload changed while stalled");

    // backpressure reaches the input only when the output register is full
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

    // the register port never waits
    assert property (@(posedge clk) disable iff (!rst_n)
        pready)
    else $error("pready dropped");

    // a bounce factor write reads back on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite &&
            paddr[pbbc_pkg::ADDR_W-1:2] == pbbc_pkg::REG_BOUNCE
        ##1 psel && !pwrite && paddr == $past(paddr)
        |-> prdata[pbbc_pkg::FACTOR_W-1:0] == $past(pwdata[pbbc_pkg::FACTOR_W-1:0]))
    else $error("bounce factor readback mismatch");

endmodule

bind particle_bounce_box_collide_core pbbc_checker u_pbbc_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .new_pos_x   (new_pos_x),
    .new_pos_y   (new_pos_y),
    .new_vel_x   (new_vel_x),
    .new_vel_y   (new_vel_y),
    .new_ang_vel (new_ang_vel),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
);

/* sim/tb_particle_bounce_box_collide_core.sv */
// self-checking testbench for particle_bounce_box_collide_core: wall bounce and settle cases
// depends on pbbc_pkg and the core; a directed table runs first, then random phases
// that use several register settings and different valid and stall patterns
module tb_particle_bounce_box_collide_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int          HOLD_CYCLES   = 80;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          PHASE_ITEMS   = 115;

    // register indexes that the core does not decode
    localparam pbbc_pkg::reg_idx_t REG_SPARE_FIRST = pbbc_pkg::REG_MIN_SPEED + 3'd1;
    localparam pbbc_pkg::reg_idx_t REG_SPARE_LAST  = '1;

    typedef enum logic {STEP_ITEM, STEP_WRITE} step_kind_t;

    typedef struct {
        step_kind_t          kind;
        pbbc_pkg::reg_idx_t  idx;
        logic [31:0]         data;
        pbbc_pkg::particle_t stim;
        logic                typed;
        pbbc_pkg::particle_t want;
    } plan_row_t;

    logic                          clk;
    logic                          rst_n    = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    pbbc_pkg::value_t              pos_x    = '0;
    pbbc_pkg::value_t              pos_y    = '0;
    pbbc_pkg::value_t              vel_x    = '0;
    pbbc_pkg::value_t              vel_y    = '0;
    pbbc_pkg::value_t              ang_vel  = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    pbbc_pkg::value_t              new_pos_x;
    pbbc_pkg::value_t              new_pos_y;
    pbbc_pkg::value_t              new_vel_x;
    pbbc_pkg::value_t              new_vel_y;
    pbbc_pkg::value_t              new_ang_vel;
    logic                          psel    = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite  = 1'b0;
    logic [pbbc_pkg::ADDR_W-1:0]   paddr   = '0;
    logic [pbbc_pkg::DATA_W-1:0]   pwdata  = '0;
    logic [pbbc_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    // register copy used by the predictor
    pbbc_pkg::limit_t    cfg_limit_x   = pbbc_pkg::LIMIT_RESET;
    pbbc_pkg::limit_t    cfg_limit_y   = pbbc_pkg::LIMIT_RESET;
    pbbc_pkg::factor_t   cfg_bounce    = pbbc_pkg::FACTOR_RESET;
    pbbc_pkg::factor_t   cfg_settle    = pbbc_pkg::FACTOR_RESET;
    pbbc_pkg::value_t    cfg_min_speed = '0;

    pbbc_pkg::particle_t awaited_particles[$];
    pbbc_pkg::particle_t arrived;
    plan_row_t           plan[$];
    int                  mismatch_count = 0;
    int unsigned         cycle_count    = 0;
    int                  tx_idle_pct    = 0;
    int                  rx_idle_pct    = 0;
    int                  hold_reqs      = 0;
    int                  hold_seen      = 0;
    int                  hold_left      = 0;

    particle_bounce_box_collide_core i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .vel_x       (vel_x),
        .vel_y       (vel_y),
        .ang_vel     (ang_vel),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .new_pos_x   (new_pos_x),
        .new_pos_y   (new_pos_y),
        .new_vel_x   (new_vel_x),
        .new_vel_y   (new_vel_y),
        .new_ang_vel (new_ang_vel),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_particle_bounce_box_collide_core NOT OK");
            $finish;
        end
    end

    // receiver stall: random, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_seen != hold_reqs)
        begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // saturate to the value range
    function automatic longint clip(longint x);
        if (x > longint'(pbbc_pkg::VALUE_MAX))
            return longint'(pbbc_pkg::VALUE_MAX);
        if (x < longint'(pbbc_pkg::VALUE_MIN))
            return longint'(pbbc_pkg::VALUE_MIN);
        return x;
    endfunction

    // v * f / 65536, rounded half up
    function automatic longint apply_factor(longint v, pbbc_pkg::factor_t f);
        return (v * longint'(f) + 32768) >>> 16;
    endfunction

    // one wall pair: p position, v own velocity, o other velocity, a angular
    function automatic void bounce_axis(inout longint p, inout longint v, inout longint o,
                                        inout longint a, input longint lim);
        logic   hit;
        logic   bounce;
        longint wall;
        longint speed;
        hit    = 1'b0;
        bounce = 1'b0;
        wall   = 0;
        speed  = longint'(cfg_min_speed);
        if (p > lim)
        begin
            hit    = 1'b1;
            wall   = lim;
            bounce = (v > speed);
        end
        else if (p < 0)
        begin
            hit    = 1'b1;
            bounce = (((v < 0) ? -v : v) > speed);
        end
        if (hit && bounce)
        begin
            p = clip(2 * wall - p);
            v = clip(-apply_factor(v, cfg_bounce));
        end
        else if (hit)
        begin
            p = clip(wall);
            v = 0;
            o = clip(apply_factor(o, cfg_settle));
            a = clip(apply_factor(a, cfg_settle));
        end
    endfunction

    // x walls first, then y walls on the updated values
    function automatic pbbc_pkg::particle_t predict_collision(pbbc_pkg::particle_t stim);
        pbbc_pkg::particle_t res;
        longint              px;
        longint              py;
        longint              vx;
        longint              vy;
        longint              av;
        px = longint'(stim.pos_x);
        py = longint'(stim.pos_y);
        vx = longint'(stim.vel_x);
        vy = longint'(stim.vel_y);
        av = longint'(stim.ang_vel);
        bounce_axis(px, vx, vy, av, longint'(cfg_limit_x));
        bounce_axis(py, vy, vx, av, longint'(cfg_limit_y));
        res.pos_x   = pbbc_pkg::value_t'(px);
        res.pos_y   = pbbc_pkg::value_t'(py);
        res.vel_x   = pbbc_pkg::value_t'(vx);
        res.vel_y   = pbbc_pkg::value_t'(vy);
        res.ang_vel = pbbc_pkg::value_t'(av);
        return res;
    endfunction

    // register write as the core sees it; spare indexes are dropped
    function automatic void note_config(pbbc_pkg::reg_idx_t idx, logic [31:0] data);
        case (idx)
            pbbc_pkg::REG_LIMIT_X:   cfg_limit_x   = pbbc_pkg::limit_t'(data);
            pbbc_pkg::REG_LIMIT_Y:   cfg_limit_y   = pbbc_pkg::limit_t'(data);
            pbbc_pkg::REG_BOUNCE:    cfg_bounce    = pbbc_pkg::factor_t'(data);
            pbbc_pkg::REG_SETTLE:    cfg_settle    = pbbc_pkg::factor_t'(data);
            pbbc_pkg::REG_MIN_SPEED: cfg_min_speed = pbbc_pkg::value_t'(data);
            default:                 ;
        endcase
    endfunction

    function automatic pbbc_pkg::particle_t make_particle(pbbc_pkg::value_t px,
                                                          pbbc_pkg::value_t py,
                                                          pbbc_pkg::value_t vx,
                                                          pbbc_pkg::value_t vy,
                                                          pbbc_pkg::value_t av);
        pbbc_pkg::particle_t p;
        p.pos_x   = px;
        p.pos_y   = py;
        p.vel_x   = vx;
        p.vel_y   = vy;
        p.ang_vel = av;
        return p;
    endfunction

    function automatic plan_row_t item_row(pbbc_pkg::particle_t stim);
        plan_row_t r;
        r.kind  = STEP_ITEM;
        r.idx   = pbbc_pkg::REG_LIMIT_X;
        r.data  = '0;
        r.stim  = stim;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic plan_row_t typed_row(pbbc_pkg::particle_t stim,
                                            pbbc_pkg::particle_t want);
        plan_row_t r;
        r       = item_row(stim);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic plan_row_t write_row(pbbc_pkg::reg_idx_t idx, logic [31:0] data);
        plan_row_t r;
        r      = item_row('0);
        r.kind = STEP_WRITE;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    // append one row to the stimulus table
    function automatic void add_row(plan_row_t r);
        plan.insert(plan.size(), r);
    endfunction

    // queue the result that an accepted transaction should produce
    function automatic void await_result(pbbc_pkg::particle_t p);
        awaited_particles.insert(awaited_particles.size(), p);
    endfunction

    // full range, near a wall or threshold, or an extreme
    function automatic pbbc_pkg::value_t pick_value(longint centre);
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 4)
            return pbbc_pkg::value_t'($urandom);
        if (pick == 8)
            return pbbc_pkg::VALUE_MAX;
        if (pick == 9)
            return pbbc_pkg::VALUE_MIN;
        return pbbc_pkg::value_t'(clip(centre + longint'($urandom_range(2048)) - 1024));
    endfunction

    function automatic pbbc_pkg::particle_t random_particle();
        pbbc_pkg::particle_t p;
        longint              speed;
        speed     = longint'(cfg_min_speed);
        p.pos_x   = pick_value($urandom_range(1) ? longint'(cfg_limit_x) : 0);
        p.pos_y   = pick_value($urandom_range(1) ? longint'(cfg_limit_y) : 0);
        p.vel_x   = pick_value($urandom_range(1) ? speed : -speed);
        p.vel_y   = pick_value($urandom_range(1) ? speed : -speed);
        p.ang_vel = pick_value(0);
        return p;
    endfunction

    task automatic check_field(input string name, input pbbc_pkg::value_t want,
                               input pbbc_pkg::value_t got);
        if (got !== want)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_particles.size() == 0)
            begin
                $error("result transaction with nothing expected");
                mismatch_count++;
            end
            else
            begin
                arrived = awaited_particles.pop_front();
                check_field("new_pos_x", arrived.pos_x, new_pos_x);
                check_field("new_pos_y", arrived.pos_y, new_pos_y);
                check_field("new_vel_x", arrived.vel_x, new_vel_x);
                check_field("new_vel_y", arrived.vel_y, new_vel_y);
                check_field("new_ang_vel", arrived.ang_vel, new_ang_vel);
            end
        end
    end

    // offer one transaction, then maybe leave gaps
    task automatic send_particle(input pbbc_pkg::particle_t stim, input logic typed,
                                 input pbbc_pkg::particle_t want);
        in_valid <= 1'b1;
        pos_x    <= stim.pos_x;
        pos_y    <= stim.pos_y;
        vel_x    <= stim.vel_x;
        vel_y    <= stim.vel_y;
        ang_vel  <= stim.ang_vel;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        await_result(typed ? want : predict_collision(stim));
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // stop offering until every result is back
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (awaited_particles.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // setup phase, access phase, then idle
    task automatic write_reg(input pbbc_pkg::reg_idx_t idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        note_config(idx, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [31:0] lx, input logic [31:0] ly,
                             input logic [31:0] bf, input logic [31:0] sf,
                             input logic [31:0] speed);
        write_reg(pbbc_pkg::REG_LIMIT_X, lx);
        write_reg(pbbc_pkg::REG_LIMIT_Y, ly);
        write_reg(pbbc_pkg::REG_BOUNCE, bf);
        write_reg(pbbc_pkg::REG_SETTLE, sf);
        write_reg(pbbc_pkg::REG_MIN_SPEED, speed);
        write_reg(pbbc_pkg::reg_idx_t'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
                  $urandom);
    endtask

    // random transactions with one long receiver hold-off
    task automatic run_phase(input int n_items, input int tx_pct, input int rx_pct);
        tx_idle_pct <= tx_pct;
        rx_idle_pct <= rx_pct;
        for (int k = 0; k < n_items; k++)
        begin
            if (k == n_items / 3)
                hold_reqs <= hold_reqs + 1;
            send_particle(random_particle(), 1'b0, '0);
        end
        drain_pipeline();
    endtask

    initial
    begin
        // reset defaults: only the left and top walls can be hit
        add_row(typed_row(make_particle(24'h100, 24'h100, 24'h100, -24'sh100, 24'h100),
                          make_particle(24'h100, 24'h100, 24'h100, -24'sh100, 24'h100)));
        add_row(typed_row(make_particle(pbbc_pkg::VALUE_MAX, pbbc_pkg::VALUE_MAX,
                                        pbbc_pkg::VALUE_MAX, pbbc_pkg::VALUE_MAX,
                                        pbbc_pkg::VALUE_MAX),
                          make_particle(pbbc_pkg::VALUE_MAX, pbbc_pkg::VALUE_MAX,
                                        pbbc_pkg::VALUE_MAX, pbbc_pkg::VALUE_MAX,
                                        pbbc_pkg::VALUE_MAX)));
        add_row(typed_row(make_particle(0, 0, 0, 0, 0), make_particle(0, 0, 0, 0, 0)));
        add_row(typed_row(make_particle(pbbc_pkg::VALUE_MIN, pbbc_pkg::VALUE_MIN,
                                        pbbc_pkg::VALUE_MIN, pbbc_pkg::VALUE_MIN,
                                        pbbc_pkg::VALUE_MIN),
                          make_particle(pbbc_pkg::VALUE_MAX, pbbc_pkg::VALUE_MAX,
                                        24'h600000, 24'h600000, pbbc_pkg::VALUE_MIN)));
        add_row(typed_row(make_particle(pbbc_pkg::VALUE_MIN, 24'h100, 24'h100, 0, 0),
                          make_particle(pbbc_pkg::VALUE_MAX, 24'h100, -192, 0, 0)));
        add_row(typed_row(make_particle(-1, 24'h100, 0, 24'h400, -24'sh400),
                          make_particle(0, 24'h100, 0, 768, -768)));

        // small box, full bounce, settle kills the rest, threshold 1.0
        add_row(write_row(pbbc_pkg::REG_LIMIT_X, 32'h0000_1000));
        add_row(write_row(pbbc_pkg::REG_LIMIT_Y, 32'h0000_2000));
        add_row(write_row(pbbc_pkg::REG_BOUNCE, 32'h0000_FFFF));
        add_row(write_row(pbbc_pkg::REG_SETTLE, 32'h0000_0000));
        add_row(write_row(pbbc_pkg::REG_MIN_SPEED, 32'h0000_0100));
        for (int s = REG_SPARE_FIRST; s <= REG_SPARE_LAST; s++)
            add_row(write_row(pbbc_pkg::reg_idx_t'(s), 32'hFFFF_FFFF));
        add_row(item_row(make_particle(24'h1100, 24'h800, 24'h200, 24'h40, 24'h300)));
        add_row(item_row(make_particle(24'h1100, 24'h800, 24'h100, 24'h40, 24'h300)));
        add_row(item_row(make_particle(24'h1100, 24'h800, -24'sh400, 24'h40, 24'h300)));
        add_row(item_row(make_particle(24'h1000, 24'h2000, 24'h500, 24'h500, 24'h10)));
        add_row(item_row(make_particle(24'h800, 24'h2100, 24'h10, 24'h200, 24'h20)));
        add_row(item_row(make_particle(24'h800, 24'h2100, 24'h10, -24'sh200, 24'h20)));
        add_row(item_row(make_particle(-24'sh80, 24'h800, -24'sh200, 24'h50, 24'h60)));
        add_row(item_row(make_particle(-24'sh80, 24'h800, -24'sh100, 24'h50, 24'h60)));
        add_row(item_row(make_particle(24'h800, -24'sh80, 24'h50, pbbc_pkg::VALUE_MAX,
                                       24'h60)));
        add_row(item_row(make_particle(24'h1100, 24'h2100, 24'h10, 24'h10,
                                       pbbc_pkg::VALUE_MAX)));
        add_row(item_row(make_particle(-24'sh100, 24'h2100, pbbc_pkg::VALUE_MIN, 24'h10,
                                       pbbc_pkg::VALUE_MIN)));

        // negative threshold, no bounce energy, half settle
        add_row(write_row(pbbc_pkg::REG_MIN_SPEED, 32'h00FF_FF00));
        add_row(write_row(pbbc_pkg::REG_SETTLE, 32'h0000_8000));
        add_row(write_row(pbbc_pkg::REG_BOUNCE, 32'h0000_0000));
        add_row(item_row(make_particle(24'h1100, 0, -24'sh80, 0, 24'h100)));
        add_row(item_row(make_particle(24'h1100, 0, -24'sh200, 0, 24'h100)));
        add_row(item_row(make_particle(-24'sh100, 24'h100, 0, 0, 0)));
        add_row(item_row(make_particle(0, 24'h2100, 24'h100, pbbc_pkg::VALUE_MIN, 24'h100)));
        // rounding ties go up
        add_row(item_row(make_particle(24'h1100, 24'h100, -24'sh200, -3, 3)));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        tx_idle_pct <= 12;
        rx_idle_pct <= 49;
        foreach (plan[i])
        begin
            if (plan[i].kind == STEP_WRITE)
            begin
                drain_pipeline();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
            begin
                send_particle(plan[i].stim, plan[i].typed, plan[i].want);
            end
        end
        drain_pipeline();

        // random phases over several register settings
        configure(32'h0000_6400, 32'h0000_3200, 32'h0000_FFFF, 32'h0000_0000, 32'h0000_0200);
        run_phase(PHASE_ITEMS, 12, 49);
        configure(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_FFFF, 32'hFF80_0000);
        run_phase(PHASE_ITEMS, 49, 12);
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_8000, 32'h0000_8000, 32'h007F_FFFF);
        run_phase(PHASE_ITEMS, 0, 0);
        configure($urandom, $urandom, $urandom, $urandom, $urandom);
        run_phase(PHASE_ITEMS, 12, 49);
        configure($urandom, $urandom, $urandom, $urandom, $urandom);
        run_phase(PHASE_ITEMS, 49, 12);
        configure($urandom_range(32'h8000), $urandom_range(32'h8000), $urandom, $urandom,
                  $urandom_range(32'h800));
        run_phase(PHASE_ITEMS, 0, 0);

        if (mismatch_count == 0)
            $display("tb_particle_bounce_box_collide_core OK");
        else
            $display("tb_particle_bounce_box_collide_core NOT OK");
        $finish;
    end

endmodule
